// ===== rtl/core/kmrb_pkg.sv =====
// kmrb_pkg: shared types and constants of the key matrix report builder
// holds the two-side keymap rom, list sizes and the cell command struct
// used by kmrb_cell and key_matrix_report_builder
package kmrb_pkg;

   localparam int LEVEL_BITS = 35;
   localparam int LIST_DEPTH = 35;
   localparam int OUT_SLOTS  = 6;
   localparam int CODE_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int ROM_ROWS   = 5;
   localparam int ROM_COLS   = 7;

   localparam logic [CODE_W-1:0] MOD_BASE = 8'hE0;

   localparam logic [CODE_W-1:0] KEYMAP_LEFT [ROM_ROWS*ROM_COLS] = '{
      8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h2A,
      8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h28,
      8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h4B,
      8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h4E,
      8'hE0, 8'h00, 8'h00, 8'h52, 8'h51, 8'hE3, 8'h00
   };

   localparam logic [CODE_W-1:0] KEYMAP_RIGHT [ROM_ROWS*ROM_COLS] = '{
      8'h2D, 8'h27, 8'h26, 8'h25, 8'h24, 8'h23, 8'h2C,
      8'h2E, 8'h13, 8'h12, 8'h0C, 8'h18, 8'h1C, 8'h2A,
      8'h34, 8'h33, 8'h0F, 8'h0E, 8'h0D, 8'h0B, 8'h4C,
      8'h31, 8'h38, 8'h37, 8'h36, 8'h10, 8'h11, 8'h46,
      8'hE6, 8'h30, 8'h2F, 8'h4F, 8'h50, 8'hE4, 8'h00
   };

   // broadcast to every list cell for one walked position
   typedef struct packed {
      logic [CODE_W-1:0] key;
      logic              append;
      logic              remove;
   } cell_cmd_type;

   // cells outside the rom read as code 0
   function automatic logic [CODE_W-1:0] keymap_code(input logic       side,
                                                     input logic [2:0] row,
                                                     input logic [2:0] col);
      logic [5:0] idx;
      idx = 6'(row) * 6'(ROM_COLS) + 6'(col);
      if (row >= 3'(ROM_ROWS) || col >= 3'(ROM_COLS)) begin
         return '0;
      end else if (side) begin
         return KEYMAP_RIGHT[idx];
      end else begin
         return KEYMAP_LEFT[idx];
      end
   endfunction

endpackage

// ===== rtl/core/kmrb_cell.sv =====
// kmrb_cell: one entry of the ordered pressed-key list
// compares against the broadcast key, appends at the tail, shifts left on delete
// depends on kmrb_pkg
module kmrb_cell (
   input  logic                         clock,
   input  kmrb_pkg::cell_cmd_type       cmd,
   input  logic                         live,
   input  logic                         tail,
   input  logic                         chain_in,
   input  logic [kmrb_pkg::CODE_W-1:0]  next_code,
   output logic                         match,
   output logic                         chain_out,
   output logic [kmrb_pkg::CODE_W-1:0]  code
);
   import kmrb_pkg::*;

   logic [CODE_W-1:0] code_ff;
   logic [CODE_W-1:0] code_in;

   assign match     = live && (code_ff == cmd.key);
   // set from the deleted entry onward
   assign chain_out = chain_in || match;
   assign code      = code_ff;

   always_comb begin
      code_in = code_ff;
      if (cmd.remove && chain_out) begin
         code_in = next_code;
      end else if (cmd.append && tail) begin
         code_in = cmd.key;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

endmodule

// ===== rtl/core/key_matrix_report_builder.sv =====
// key_matrix_report_builder: scan compare, position walker and report registers
// instantiates a row of kmrb_cell list entries; depends on kmrb_pkg
//
// A scan is taken when start is high and busy is low. A scan equal to the last one gives its
// strobe on rsp_valid in the next cycle with report_changed low and the last report repeated.
// A changed scan walks one matrix position per cycle, column by column, through the row of
// list cells, then passes through the report state to its registered strobe; busy stays high
// until the strobe cycle. The receiver cannot stall: each result is on rsp_* for the one cycle
// rsp_valid is high, and the fields keep the last report afterwards.
// keyboard_side is read per walked position, so a write mid-walk applies to the rest of it.
module key_matrix_report_builder #(
   parameter int MATRIX_ROWS  = 5,
   parameter int MATRIX_COLS  = 7,
   parameter int REPORT_SLOTS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [kmrb_pkg::LEVEL_BITS-1:0]  req_key_levels,
   output logic                             rsp_valid,
   output logic                             rsp_report_changed,
   output logic [7:0]                       rsp_modifier_mask,
   output logic [kmrb_pkg::CODE_W-1:0]      rsp_key_slot_0,
   output logic [kmrb_pkg::CODE_W-1:0]      rsp_key_slot_1,
   output logic [kmrb_pkg::CODE_W-1:0]      rsp_key_slot_2,
   output logic [kmrb_pkg::CODE_W-1:0]      rsp_key_slot_3,
   output logic [kmrb_pkg::CODE_W-1:0]      rsp_key_slot_4,
   output logic [kmrb_pkg::CODE_W-1:0]      rsp_key_slot_5,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_keyboard_side
);
   import kmrb_pkg::*;

   localparam int ROW_W = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
   localparam int COL_W = (MATRIX_COLS > 1) ? $clog2(MATRIX_COLS) : 1;
   localparam int WALK_BITS = (MATRIX_ROWS * MATRIX_COLS < LEVEL_BITS) ?
                              MATRIX_ROWS * MATRIX_COLS : LEVEL_BITS;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MATRIX_ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MATRIX_COLS - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [LEVEL_BITS-1:0] lv_ff, lv_in;
   logic [LEVEL_BITS-1:0] prev_ff, prev_in;
   logic [7:0]            mod_ff, mod_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  side_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_changed_ff, rsp_changed_in;
   logic [7:0]            rsp_mod_ff, rsp_mod_in;
   logic [CODE_W-1:0]     slot_ff [OUT_SLOTS];
   logic [CODE_W-1:0]     slot_in [OUT_SLOTS];

   logic [LEVEL_BITS-1:0] walk_mask;
   logic [LEVEL_BITS-1:0] scan_masked;
   logic                  scan_changed;
   logic [6:0]            bit_idx;
   logic                  pressed;
   logic [CODE_W-1:0]     key_code;
   logic                  walking;
   logic                  found;
   logic                  full;
   cell_cmd_type          cmd;

   logic [CODE_W-1:0]     cell_code [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] match_vec;
   logic [LIST_DEPTH-1:0] chain_vec;
   logic [LIST_DEPTH-1:0] live_vec;
   logic [LIST_DEPTH-1:0] tail_vec;

   always_comb begin
      for (int b = 0; b < LEVEL_BITS; b++) begin
         walk_mask[b] = (b < WALK_BITS);
      end
   end

   assign scan_masked  = req_key_levels & walk_mask;
   assign scan_changed = (scan_masked != prev_ff);
   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;

   assign walking  = (state_ff == ST_WALK);
   assign bit_idx  = 7'(row_ff) * 7'(MATRIX_COLS) + 7'(col_ff);
   // positions past the input width read as released
   assign pressed  = (bit_idx < 7'(LEVEL_BITS)) && lv_ff[bit_idx[5:0]];
   assign key_code = keymap_code(side_ff, 3'(row_ff), 3'(col_ff));
   assign found    = |match_vec;
   assign full     = (count_ff == COUNT_W'(LIST_DEPTH));

   assign cmd.key    = key_code;
   assign cmd.append = walking && pressed && !found && !full;
   assign cmd.remove = walking && !pressed;

   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         assign live_vec[gi] = (COUNT_W'(gi) < count_ff);
         assign tail_vec[gi] = (COUNT_W'(gi) == count_ff);
         if (gi == 0) begin : g_head
            kmrb_cell u_cell (
               .clock     (clock),
               .cmd       (cmd),
               .live      (live_vec[gi]),
               .tail      (tail_vec[gi]),
               .chain_in  (1'b0),
               .next_code (cell_code[gi+1]),
               .match     (match_vec[gi]),
               .chain_out (chain_vec[gi]),
               .code      (cell_code[gi])
            );
         end else if (gi == LIST_DEPTH - 1) begin : g_last
            kmrb_cell u_cell (
               .clock     (clock),
               .cmd       (cmd),
               .live      (live_vec[gi]),
               .tail      (tail_vec[gi]),
               .chain_in  (chain_vec[gi-1]),
               .next_code (cell_code[gi]),
               .match     (match_vec[gi]),
               .chain_out (chain_vec[gi]),
               .code      (cell_code[gi])
            );
         end else begin : g_mid
            kmrb_cell u_cell (
               .clock     (clock),
               .cmd       (cmd),
               .live      (live_vec[gi]),
               .tail      (tail_vec[gi]),
               .chain_in  (chain_vec[gi-1]),
               .next_code (cell_code[gi+1]),
               .match     (match_vec[gi]),
               .chain_out (chain_vec[gi]),
               .code      (cell_code[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      lv_in          = lv_ff;
      prev_in        = prev_ff;
      mod_in         = mod_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_changed_in = rsp_changed_ff;
      rsp_mod_in     = rsp_mod_ff;
      for (int i = 0; i < OUT_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               prev_in = scan_masked;
               lv_in   = scan_masked;
               if (scan_changed) begin
                  state_in = ST_WALK;
                  row_in   = '0;
                  col_in   = '0;
                  mod_in   = '0;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_changed_in = 1'b0;
               end
            end
         end
         ST_WALK: begin
            if (pressed && key_code >= MOD_BASE) begin
               mod_in = mod_ff | (8'b1 << key_code[2:0]);
            end
            if (cmd.append) begin
               count_in = count_ff + COUNT_W'(1);
            end else if (cmd.remove && found) begin
               count_in = count_ff - COUNT_W'(1);
            end
            // rows inner, columns outer
            if (row_ff == LAST_ROW) begin
               row_in = '0;
               col_in = col_ff + COL_W'(1);
               if (col_ff == LAST_COL) begin
                  state_in = ST_REPORT;
               end
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_REPORT: begin
            rsp_valid_in   = 1'b1;
            rsp_changed_in = 1'b1;
            rsp_mod_in     = mod_ff;
            for (int i = 0; i < OUT_SLOTS; i++) begin
               slot_in[i] = (i < REPORT_SLOTS && live_vec[i]) ? cell_code[i] : '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_ff         <= '0;
         col_ff         <= '0;
         prev_ff        <= '0;
         count_ff       <= '0;
         side_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_changed_ff <= 1'b0;
         rsp_mod_ff     <= '0;
         for (int i = 0; i < OUT_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         prev_ff        <= prev_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_mod_ff     <= rsp_mod_in;
         for (int i = 0; i < OUT_SLOTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
         if (csr_valid && csr_ready) begin
            side_ff <= csr_keyboard_side;
         end
      end
   end

   always_ff @(posedge clock) begin
      lv_ff  <= lv_in;
      mod_ff <= mod_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_report_changed = rsp_changed_ff;
   assign rsp_modifier_mask  = rsp_mod_ff;
   assign rsp_key_slot_0     = slot_ff[0];
   assign rsp_key_slot_1     = slot_ff[1];
   assign rsp_key_slot_2     = slot_ff[2];
   assign rsp_key_slot_3     = slot_ff[3];
   assign rsp_key_slot_4     = slot_ff[4];
   assign rsp_key_slot_5     = slot_ff[5];

`ifndef SYNTH
   // list depth bounds the fill count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(LIST_DEPTH))
      else $error("pressed count beyond list depth");

   // live entries hold distinct codes, so at most one cell matches
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key code matched in more than one cell");

   // the strobe cycle is also a cycle that can take the next request
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_unchanged_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !scan_changed) |=> (rsp_valid && !rsp_report_changed))
      else $error("unchanged scan did not answer next cycle");

   a_walk_report: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |=> (rsp_valid && rsp_report_changed))
      else $error("walk end without changed report");
`endif

endmodule

// ===== verif/key_matrix_report_checker.sv =====
// key_matrix_report_checker: watches the scan, report and side channels of the
// key matrix report builder, predicts every report and compares it field by field
// depends on kmrb_pkg for widths and the two keymap tables
module key_matrix_report_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [kmrb_pkg::LEVEL_BITS-1:0]   req_key_levels,
   input  logic                              rsp_valid,
   input  logic                              rsp_report_changed,
   input  logic [7:0]                        rsp_modifier_mask,
   input  logic [kmrb_pkg::CODE_W-1:0]       rsp_key_slot_0,
   input  logic [kmrb_pkg::CODE_W-1:0]       rsp_key_slot_1,
   input  logic [kmrb_pkg::CODE_W-1:0]       rsp_key_slot_2,
   input  logic [kmrb_pkg::CODE_W-1:0]       rsp_key_slot_3,
   input  logic [kmrb_pkg::CODE_W-1:0]       rsp_key_slot_4,
   input  logic [kmrb_pkg::CODE_W-1:0]       rsp_key_slot_5,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic                              csr_keyboard_side,
   output int                                mismatch_count,
   output int                                reports_pending
);
   import kmrb_pkg::*;

   typedef struct packed {
      logic                              changed;
      logic [7:0]                        modifiers;
      logic [OUT_SLOTS-1:0][CODE_W-1:0]  slots;
   } hid_report_type;

   hid_report_type expected_reports [$];

   // predicted keyboard state
   logic                              side_sel;
   logic [LEVEL_BITS-1:0]             held_levels;
   logic [CODE_W-1:0]                 key_list [LIST_DEPTH];
   int                                key_count;
   logic [7:0]                        held_modifiers;
   logic [OUT_SLOTS-1:0][CODE_W-1:0]  held_slots;

   logic [OUT_SLOTS-1:0][CODE_W-1:0]  seen_slots;

   assign seen_slots = {rsp_key_slot_5, rsp_key_slot_4, rsp_key_slot_3,
                        rsp_key_slot_2, rsp_key_slot_1, rsp_key_slot_0};

   function automatic int find_key(input logic [CODE_W-1:0] code);
      for (int i = 0; i < key_count; i++) begin
         if (key_list[i] == code) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic hid_report_type build_report(input logic [LEVEL_BITS-1:0] levels);
      hid_report_type    rep;
      logic [CODE_W-1:0] code;
      logic [7:0]        mods;
      int                pos;
      rep.changed = (levels != held_levels);
      held_levels = levels;
      if (rep.changed) begin
         mods = '0;
         // column by column, rows inner
         for (int c = 0; c < ROM_COLS; c++) begin
            for (int r = 0; r < ROM_ROWS; r++) begin
               code = side_sel ? KEYMAP_RIGHT[r*ROM_COLS+c] : KEYMAP_LEFT[r*ROM_COLS+c];
               pos  = find_key(code);
               if (levels[r*ROM_COLS+c]) begin
                  if (code[7:3] == MOD_BASE[7:3]) begin
                     mods[code[2:0]] = 1'b1;
                  end
                  if (pos < 0 && key_count < LIST_DEPTH) begin
                     key_list[key_count] = code;
                     key_count++;
                  end
               end else if (pos >= 0) begin
                  for (int i = pos; i < key_count - 1; i++) begin
                     key_list[i] = key_list[i+1];
                  end
                  key_count--;
               end
            end
         end
         held_modifiers = mods;
         for (int i = 0; i < OUT_SLOTS; i++) begin
            held_slots[i] = (i < key_count) ? key_list[i] : '0;
         end
      end
      rep.modifiers = held_modifiers;
      rep.slots     = held_slots;
      return rep;
   endfunction

   function automatic bit field_ok(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
      if (want === got) begin
         return 1'b1;
      end
      $display("%0t %s mismatch: expected %02h actual %02h", $time, field, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      hid_report_type want;
      bit             good;
      if (reset) begin
         side_sel       = 1'b0;
         held_levels    = '0;
         key_count      = 0;
         held_modifiers = '0;
         held_slots     = '0;
         mismatch_count = 0;
         expected_reports.delete();
      end else begin
         // compare first so a report never meets the request accepted at the same edge
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $display("%0t report with no request waiting: expected none actual %h",
                        $time, {rsp_report_changed, rsp_modifier_mask, seen_slots});
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               good = field_ok("report_changed", 8'(want.changed), 8'(rsp_report_changed));
               good &= field_ok("modifier_mask", want.modifiers, rsp_modifier_mask);
               for (int i = 0; i < OUT_SLOTS; i++) begin
                  good &= field_ok($sformatf("key_slot_%0d", i), want.slots[i],
                                   seen_slots[i]);
               end
               if (!good) begin
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            side_sel = csr_keyboard_side;
         end
         if (start && !busy) begin
            expected_reports.push_back(build_report(req_key_levels));
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

// ===== verif/key_matrix_report_builder_test.sv =====
// key_matrix_report_builder_test: drives scans and keymap side writes into the
// key matrix report builder; the checker beside it predicts and compares
// depends on kmrb_pkg, key_matrix_report_builder and key_matrix_report_checker
module key_matrix_report_builder_test;
   import kmrb_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASE_SCANS  = 225;
   localparam int TAIL_CYCLES  = 40;
   localparam logic [LEVEL_BITS-1:0] ALL_KEYS = {LEVEL_BITS{1'b1}};

   localparam logic [LEVEL_BITS-1:0] LEFT_SCANS [12] = '{
      35'h0_0000_0000,     // same as after reset
      35'h7_FFFF_FFFF,     // every key: empty cells and a repeated code
      35'h7_FFFF_FFFF,
      35'h0_0000_0000,
      35'h0_0000_0001,
      35'h4_0000_0000,
      35'h2_1020_0000,     // left modifiers only
      35'h5_5555_5555,
      35'h2_AAAA_AAAA,
      35'h0_0000_007F,     // top row
      35'h0_0000_3FFF,     // more keys than slots
      35'h0_0000_3F80      // release from the head of the list
   };

   // second row stays held across the side change
   localparam logic [LEVEL_BITS-1:0] RIGHT_SCANS [8] = '{
      35'h7_FFFF_FFFF,
      35'h0_0000_0000,
      35'h2_1000_0000,
      35'h0_0000_2000,
      35'h0_0000_2040,
      35'h1_0000_0000,
      35'h4_0000_0000,
      35'h4_0000_0000
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [LEVEL_BITS-1:0]  req_key_levels;
   logic                   rsp_valid;
   logic                   rsp_report_changed;
   logic [7:0]             rsp_modifier_mask;
   logic [CODE_W-1:0]      rsp_key_slot_0;
   logic [CODE_W-1:0]      rsp_key_slot_1;
   logic [CODE_W-1:0]      rsp_key_slot_2;
   logic [CODE_W-1:0]      rsp_key_slot_3;
   logic [CODE_W-1:0]      rsp_key_slot_4;
   logic [CODE_W-1:0]      rsp_key_slot_5;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_keyboard_side;
   int                     mismatch_count;
   int                     reports_pending;
   int                     idle_cycles = 0;

   key_matrix_report_builder dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_key_levels     (req_key_levels),
      .rsp_valid          (rsp_valid),
      .rsp_report_changed (rsp_report_changed),
      .rsp_modifier_mask  (rsp_modifier_mask),
      .rsp_key_slot_0     (rsp_key_slot_0),
      .rsp_key_slot_1     (rsp_key_slot_1),
      .rsp_key_slot_2     (rsp_key_slot_2),
      .rsp_key_slot_3     (rsp_key_slot_3),
      .rsp_key_slot_4     (rsp_key_slot_4),
      .rsp_key_slot_5     (rsp_key_slot_5),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_keyboard_side  (csr_keyboard_side)
   );

   key_matrix_report_checker report_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_key_levels     (req_key_levels),
      .rsp_valid          (rsp_valid),
      .rsp_report_changed (rsp_report_changed),
      .rsp_modifier_mask  (rsp_modifier_mask),
      .rsp_key_slot_0     (rsp_key_slot_0),
      .rsp_key_slot_1     (rsp_key_slot_1),
      .rsp_key_slot_2     (rsp_key_slot_2),
      .rsp_key_slot_3     (rsp_key_slot_3),
      .rsp_key_slot_4     (rsp_key_slot_4),
      .rsp_key_slot_5     (rsp_key_slot_5),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_keyboard_side  (csr_keyboard_side),
      .mismatch_count     (mismatch_count),
      .reports_pending    (reports_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycles with no request, report or side write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL key_matrix_report_builder");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge that accepts the request
   task automatic issue_scan(input logic [LEVEL_BITS-1:0] levels);
      start          <= 1'b1;
      req_key_levels <= levels;
      @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_reports();
      start <= 1'b0;
      @(negedge clock);
      while (reports_pending != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_side(input logic side);
      csr_valid         <= 1'b1;
      csr_keyboard_side <= side;
      @(negedge clock);
      while (!csr_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly typing: a few keys go down or up, sometimes nothing moves
   function automatic logic [LEVEL_BITS-1:0] next_scan(input logic [LEVEL_BITS-1:0] held);
      logic [LEVEL_BITS-1:0] scan;
      int                    pick;
      scan = held;
      pick = $urandom_range(99);
      if (pick < 15) begin
         scan = held;
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 3)) begin
            scan[$urandom_range(LEVEL_BITS-1)] ^= 1'b1;
         end
      end else if (pick < 92) begin
         scan = {3'($urandom_range(7)), 32'($urandom())};
      end else if (pick < 96) begin
         scan = '0;
      end else begin
         scan = ALL_KEYS;
      end
      return scan;
   endfunction

   initial begin
      logic [LEVEL_BITS-1:0] typed_levels;
      int                    sent;
      int                    burst;
      int                    gap;
      reset             = 1'b1;
      start             = 1'b0;
      req_key_levels    = '0;
      csr_valid         = 1'b0;
      csr_keyboard_side = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_side(1'b0);
      foreach (LEFT_SCANS[i]) begin
         issue_scan(LEFT_SCANS[i]);
      end
      drain_reports();
      write_side(1'b1);
      foreach (RIGHT_SCANS[i]) begin
         issue_scan(RIGHT_SCANS[i]);
      end
      drain_reports();

      typed_levels = RIGHT_SCANS[7];
      for (int phase = 0; phase < 8; phase++) begin
         write_side(1'((phase % 2) ^ ((phase / 4) % 2)));
         sent = 0;
         while (sent < PHASE_SCANS) begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && sent < PHASE_SCANS; k++) begin
               typed_levels = next_scan(typed_levels);
               issue_scan(typed_levels);
               sent++;
            end
            // one phase runs back to back with no gaps
            gap = (phase == 3) ? 0 : $urandom_range(0, 45);
            if (gap != 0) begin
               idle_gap(gap);
            end
         end
         drain_reports();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("PASS key_matrix_report_builder");
      end else begin
         $display("FAIL key_matrix_report_builder");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/kmrb_pkg.sv
rtl/core/kmrb_cell.sv
rtl/core/key_matrix_report_builder.sv
verif/key_matrix_report_checker.sv
verif/key_matrix_report_builder_test.sv
